@@ design/packet_reorder_jitter_buffer_top_macros.svh @@
// Assertion macros shared by the jitter buffer RTL.
`ifndef PACKET_REORDER_JITTER_BUFFER_TOP_MACROS_SVH
`define PACKET_REORDER_JITTER_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PRJB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jitter buffer assertion failed");

// Next-cycle implication, disabled while in reset.
`define PRJB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jitter buffer assertion failed");

`endif

@@ design/prjb_pkg.sv @@
// Shared constants, codes and types of the jitter buffer.
package prjb_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int SEQ_BITS    = 32;
   // slots are indexed by sequence modulo twice the maximum window
   localparam int SLOTS       = 2 * MAX_ENTRIES;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int FILL_W      = 7;
   localparam int TF_W        = 6;
   localparam int TS_W        = 32;
   localparam int PL_W        = 16;
   localparam int CNT_W       = 32;
   localparam int N_STATS     = 5;
   localparam int ENTRY_W     = TS_W + PL_W;

   localparam logic [TF_W-1:0] TF_RESET = TF_W'(4);

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_FLUSH = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      RC_ACCEPTED  = 3'd0,
      RC_DUPLICATE = 3'd1,
      RC_AHEAD     = 3'd2,
      RC_NOT_READY = 3'd3,
      RC_PACKET    = 3'd4,
      RC_CONCEAL   = 3'd5,
      RC_UNDERRUN  = 3'd6,
      RC_FLUSHED   = 3'd7
   } code_type;

   localparam int STAT_RECV  = 0;
   localparam int STAT_DUP   = 1;
   localparam int STAT_LATE  = 2;
   localparam int STAT_DROP  = 3;
   localparam int STAT_UNDER = 4;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } head_type;

endpackage

@@ design/prjb_ifs.sv @@
// Channel interfaces: request, response and register write.
interface prjb_req_if import prjb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [31:0]         sequence_req;
   logic [TS_W-1:0]     timestamp;
   logic [PL_W-1:0]     payload_handle;
   modport source(output valid, func, sequence_req, timestamp, payload_handle, input ready);
   modport sink(input valid, func, sequence_req, timestamp, payload_handle, output ready);
endinterface

interface prjb_rsp_if import prjb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [2:0]          result_code;
   logic [31:0]         out_sequence;
   logic [TS_W-1:0]     out_timestamp;
   logic [PL_W-1:0]     out_payload;
   logic [FILL_W-1:0]   fill_level;
   logic                ready_res;
   logic [CNT_W-1:0]    count_received;
   logic [CNT_W-1:0]    count_duplicate;
   logic [CNT_W-1:0]    count_late;
   logic [CNT_W-1:0]    count_dropped;
   logic [CNT_W-1:0]    count_underrun;
   logic [FILL_W-1:0]   max_fill;
   modport source(output valid, result_code, out_sequence, out_timestamp, out_payload,
                  fill_level, ready_res, count_received, count_duplicate, count_late,
                  count_dropped, count_underrun, max_fill, input ready);
   modport sink(input valid, result_code, out_sequence, out_timestamp, out_payload,
                fill_level, ready_res, count_received, count_duplicate, count_late,
                count_dropped, count_underrun, max_fill, output ready);
endinterface

interface prjb_csr_if import prjb_pkg::*;;
   logic              valid;
   logic              ready;
   logic [TF_W-1:0]   target_fill;
   modport source(output valid, target_fill, input ready);
   modport sink(input valid, target_fill, output ready);
endinterface

@@ design/packet_reorder_jitter_buffer_top.sv @@
// Sequence-ordered jitter buffer: slot RAM indexed by sequence, occupancy map, stats.
// Each operation steps through accept, head search with RAM read, and update.
// A new request is taken only once the previous one has left the update state.
// The response register frees the input side while a result waits for transfer.
// Synchronous reset clears fill, expected sequence and stats, sets target fill to 4.
// Slot RAM contents are not cleared; the occupancy map tells which slots are live.
module packet_reorder_jitter_buffer_top import prjb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   prjb_req_if.sink   req_ch,
   prjb_rsp_if.source rsp_ch,
   prjb_csr_if.sink   csr_ch
);

`include "packet_reorder_jitter_buffer_top_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_FIND = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   func_type               op_ff;
   logic [SEQ_BITS-1:0]    seq_ff;
   logic [TS_W-1:0]        ts_ff;
   logic [PL_W-1:0]        pl_ff;
   head_type               head_ff, head_c;
   logic [SLOTS-1:0]       occ_ff, occ_in;
   logic [FILL_W-1:0]      count_ff, count_in;
   logic [SEQ_BITS-1:0]    exp_ff, exp_in;
   logic                   started_ff, started_in;
   logic [CNT_W-1:0]       stat_ff [N_STATS];
   logic [CNT_W-1:0]       stat_in [N_STATS];
   logic [FILL_W-1:0]      peak_ff, peak_in;
   logic [TF_W-1:0]        tf_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   code_type               code_c;
   logic [31:0]            oseq_c;
   logic [TS_W-1:0]        ots_c;
   logic [PL_W-1:0]        opl_c;

   logic                   req_xfer;
   logic                   out_free;
   logic                   fire;
   logic [SEQ_BITS-1:0]    eff_exp;
   logic [FILL_W-1:0]      cap;
   logic [TF_W:0]          tf_dbl;
   logic                   wr_en_c;
   logic [ENTRY_W-1:0]     rd_data;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
      return (&x) ? x : x + 1'b1;
   endfunction

   assign req_xfer     = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = (state_ff == ST_DONE) && out_free;

   // first push seeds the expected sequence
   assign eff_exp = started_ff ? exp_ff : seq_ff;

   // capacity: twice target, limited to MAX_ENTRIES, at least one
   assign tf_dbl = {tf_ff, 1'b0};
   always_comb begin
      if (tf_ff == '0) begin
         cap = FILL_W'(1);
      end else if (FILL_W'(tf_dbl) > FILL_W'(MAX_ENTRIES)) begin
         cap = FILL_W'(MAX_ENTRIES);
      end else begin
         cap = FILL_W'(tf_dbl);
      end
   end

   prjb_head_find u_head (
      .occ   (occ_ff),
      .start (eff_exp[SLOT_W-1:0]),
      .head  (head_c)
   );

   prjb_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en_c),
      .wr_addr (seq_ff[SLOT_W-1:0]),
      .wr_data ({ts_ff, pl_ff}),
      .rd_en   (state_ff == ST_FIND),
      .rd_addr (exp_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_FIND;
         ST_FIND: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // operation update
   always_comb begin
      occ_in     = occ_ff;
      count_in   = count_ff;
      exp_in     = exp_ff;
      started_in = started_ff;
      peak_in    = peak_ff;
      for (int k = 0; k < N_STATS; k++) begin
         stat_in[k] = stat_ff[k];
      end
      code_c  = RC_NOT_READY;
      oseq_c  = '0;
      ots_c   = '0;
      opl_c   = '0;
      wr_en_c = 1'b0;
      if (fire) begin
         case (op_ff)
            FUNC_PUSH: begin
               stat_in[STAT_RECV] = sat_inc(stat_ff[STAT_RECV]);
               exp_in     = eff_exp;
               started_in = 1'b1;
               if (seq_ff < eff_exp) begin
                  stat_in[STAT_DUP] = sat_inc(stat_ff[STAT_DUP]);
                  code_c = RC_DUPLICATE;
               end else if ({1'b0, seq_ff} > {1'b0, eff_exp} + (SEQ_BITS+1)'(cap)) begin
                  stat_in[STAT_LATE] = sat_inc(stat_ff[STAT_LATE]);
                  code_c = RC_AHEAD;
               end else if (occ_ff[seq_ff[SLOT_W-1:0]]) begin
                  stat_in[STAT_DUP] = sat_inc(stat_ff[STAT_DUP]);
                  code_c = RC_DUPLICATE;
               end else begin
                  if (count_ff >= cap) begin
                     stat_in[STAT_DROP] = sat_inc(stat_ff[STAT_DROP]);
                     occ_in[head_ff.idx] = 1'b0;
                     count_in = count_in - 1'b1;
                  end
                  occ_in[seq_ff[SLOT_W-1:0]] = 1'b1;
                  count_in = count_in + 1'b1;
                  wr_en_c  = 1'b1;
                  if (count_in > peak_ff) begin
                     peak_in = count_in;
                  end
                  code_c = RC_ACCEPTED;
               end
            end
            FUNC_POP: begin
               if (count_ff < FILL_W'(tf_ff)) begin
                  code_c = RC_NOT_READY;
               end else if (count_ff == '0) begin
                  if (started_ff) begin
                     stat_in[STAT_UNDER] = sat_inc(stat_ff[STAT_UNDER]);
                     code_c = RC_UNDERRUN;
                  end
               end else if (occ_ff[exp_ff[SLOT_W-1:0]]) begin
                  code_c = RC_PACKET;
                  oseq_c = 32'(exp_ff);
                  {ots_c, opl_c} = rd_data;
                  occ_in[exp_ff[SLOT_W-1:0]] = 1'b0;
                  count_in = count_ff - 1'b1;
                  exp_in   = exp_ff + 1'b1;
               end else begin
                  code_c = RC_CONCEAL;
                  oseq_c = 32'(exp_ff);
                  exp_in = exp_ff + 1'b1;
                  stat_in[STAT_LATE] = sat_inc(stat_ff[STAT_LATE]);
               end
            end
            FUNC_FLUSH: begin
               occ_in     = '0;
               count_in   = '0;
               exp_in     = '0;
               started_in = 1'b0;
               peak_in    = '0;
               for (int k = 0; k < N_STATS; k++) begin
                  stat_in[k] = '0;
               end
               code_c = RC_FLUSHED;
            end
            default: code_c = RC_NOT_READY;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         count_ff     <= '0;
         exp_ff       <= '0;
         started_ff   <= 1'b0;
         peak_ff      <= '0;
         tf_ff        <= TF_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < N_STATS; k++) begin
            stat_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         exp_ff       <= exp_in;
         started_ff   <= started_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < N_STATS; k++) begin
            stat_ff[k] <= stat_in[k];
         end
         if (csr_ch.valid) begin
            tf_ff <= csr_ch.target_fill;
         end
      end
   end

   // item capture, head search result
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= func_type'(req_ch.func);
         seq_ff <= req_ch.sequence_req[SEQ_BITS-1:0];
         ts_ff  <= req_ch.timestamp;
         pl_ff  <= req_ch.payload_handle;
      end
      if (state_ff == ST_FIND) begin
         head_ff <= head_c;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ch.result_code     <= code_c;
         rsp_ch.out_sequence    <= oseq_c;
         rsp_ch.out_timestamp   <= ots_c;
         rsp_ch.out_payload     <= opl_c;
         rsp_ch.fill_level      <= count_in;
         rsp_ch.ready_res       <= (count_in >= FILL_W'(tf_ff));
         rsp_ch.count_received  <= stat_in[STAT_RECV];
         rsp_ch.count_duplicate <= stat_in[STAT_DUP];
         rsp_ch.count_late      <= stat_in[STAT_LATE];
         rsp_ch.count_dropped   <= stat_in[STAT_DROP];
         rsp_ch.count_underrun  <= stat_in[STAT_UNDER];
         rsp_ch.max_fill        <= peak_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

   `PRJB_ASSERT_NOW(a_fill_matches_map, 1'b1, $countones(occ_ff) == 32'(count_ff))
   `PRJB_ASSERT_NOW(a_fill_bound, 1'b1, count_ff <= FILL_W'(MAX_ENTRIES))
   `PRJB_ASSERT_NOW(a_peak_covers_fill, 1'b1, peak_ff >= count_ff)
   `PRJB_ASSERT_NEXT(a_accept_starts_search, req_xfer, state_ff == ST_FIND)
   `PRJB_ASSERT_NOW(a_evict_has_head, fire && wr_en_c && count_ff >= cap, head_ff.found)

endmodule

@@ design/prjb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module prjb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ design/prjb_head_find.sv @@
// Finds the first occupied slot at or after the expected slot, circularly.
module prjb_head_find import prjb_pkg::*; (
   input  logic [SLOTS-1:0]  occ,
   input  logic [SLOT_W-1:0] start,
   output head_type          head
);

   logic [2*SLOTS-1:0] dbl;
   logic [SLOT_W-1:0]  idx;

   // unroll the ring twice so the search never has to wrap
   assign dbl = {occ, occ};

   // priority scan from the top: lowest occupied slot at or after start wins
   always_comb begin
      idx = '0;
      for (int i = 2*SLOTS-1; i >= 0; i--) begin
         if (dbl[i] && ((SLOT_W+1)'(i) >= {1'b0, start})) begin
            idx = SLOT_W'(i);
         end
      end
   end

   assign head.found = |occ;
   assign head.idx   = idx;

endmodule
